// ===== src/modbus_rtu_response_checker_defines.svh =====
// Assertion macros for the Modbus RTU response checker.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MRRC_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MRRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mrrc_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the response checker.
`default_nettype none
package mrrc_pkg;

    localparam int RX_BUFFER_BYTES_DEF = 64;
    localparam int LAST_READ_CODE_DEF  = 4;
    localparam int FIFO_DEPTH          = 4;

    localparam logic [15:0] CRC_SEED      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_KEEP      = 16'h7FFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_TICK  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        REASON_NONE  = 2'd0,
        REASON_ECHO  = 2'd1,
        REASON_SHORT = 2'd2,
        REASON_CRC   = 2'd3
    } reason_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_LISTEN = 1'b1
    } state_t;

    typedef struct packed {
        action_t    kind;
        logic [7:0] data;
    } cmd_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = ((c >> 1) & CRC_KEEP) ^ CRC_POLY;
            else
                c = (c >> 1) & CRC_KEEP;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== src/mrrc_front.sv =====
// Input side: accept words, decode the action and queue commands.
`default_nettype none
module mrrc_front
    import mrrc_pkg::*;
(
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic [15:0] s_axis_tdata,
    input  wire logic        q_full,
    output logic             q_push,
    output cmd_t             q_cmd
);

    logic accept;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        q_push      = 1'b0;
        q_cmd.kind  = ACT_TICK;
        q_cmd.data  = s_axis_tdata[15:8];
        unique case (s_axis_tuser)
            ACT_START:
            begin
                q_push     = accept;
                q_cmd.kind = ACT_START;
                q_cmd.data = s_axis_tdata[7:0];
            end
            ACT_BYTE:
            begin
                q_push     = accept;
                q_cmd.kind = ACT_BYTE;
            end
            ACT_TICK:
            begin
                q_push     = accept;
                q_cmd.kind = ACT_TICK;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/mrrc_fifo.sv =====
// Short command queue between the decode and execute sides.
`default_nettype none
module mrrc_fifo
    import mrrc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      head
);

    localparam int AW = $clog2(FIFO_DEPTH);

    cmd_t              mem_reg [FIFO_DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW:0]       count_reg, count_next;

    assign full      = (count_reg == (AW+1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule
`default_nettype wire

// ===== src/mrrc_back.sv =====
// Execute side: frame state, CRC-16, idle timer and the result register.
`default_nettype none
module mrrc_back
    import mrrc_pkg::*;
#(
    parameter int RX_BUFFER_BYTES = RX_BUFFER_BYTES_DEF,
    parameter int LAST_READ_CODE  = LAST_READ_CODE_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic [15:0] cfg_data,
    input  wire logic        q_not_empty,
    input  wire cmd_t        q_head,
    output logic             q_pop,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata
);

    localparam logic [7:0] RX_LIMIT  = 8'(RX_BUFFER_BYTES);
    localparam logic [8:0] RX_LEN    = 9'(RX_BUFFER_BYTES);
    localparam logic [7:0] LAST_READ = 8'(LAST_READ_CODE);

    state_t      state_reg, state_next;
    logic [15:0] timeout_reg;
    logic [7:0]  expected_reg, expected_next;
    logic [7:0]  count_reg, count_next;
    logic [8:0]  left_reg, left_next, left_dec;
    logic        echo_bad_reg, echo_bad_next;
    logic [15:0] idle_reg, idle_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  last0_reg, last0_next;
    logic [7:0]  last1_reg, last1_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;
    logic        close;
    logic        res_ok;
    reason_t     res_reason;

    assign q_pop         = q_not_empty && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next    = state_reg;
        expected_next = expected_reg;
        count_next    = count_reg;
        left_next     = left_reg;
        echo_bad_next = echo_bad_reg;
        idle_next     = idle_reg;
        crc_next      = crc_reg;
        last0_next    = last0_reg;
        last1_next    = last1_reg;
        left_dec      = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
        close         = 1'b0;

        if (q_pop)
        begin
            unique case (q_head.kind)
                ACT_START:
                begin
                    state_next    = ST_LISTEN;
                    expected_next = q_head.data;
                    count_next    = '0;
                    left_next     = '0;
                    echo_bad_next = 1'b0;
                    idle_next     = '0;
                    crc_next      = CRC_SEED;
                    last0_next    = '0;
                    last1_next    = '0;
                end
                ACT_BYTE:
                begin
                    if (state_reg == ST_LISTEN)
                    begin
                        if (count_reg >= 8'd2)
                            crc_next = crc_byte(crc_reg, last0_reg);
                        last0_next = last1_reg;
                        last1_next = q_head.data;
                        count_next = count_reg + 1'b1;
                        idle_next  = '0;
                        if (count_next == 8'd2)
                        begin
                            if (q_head.data != expected_reg)
                                echo_bad_next = 1'b1;
                        end
                        else if (count_next == 8'd3)
                        begin
                            if (expected_reg <= LAST_READ)
                                left_next = {1'b0, q_head.data} + 9'd2;
                            else
                                left_next = RX_LEN;
                        end
                        else if (count_next > 8'd3)
                        begin
                            left_next = left_dec;
                            if (left_dec == '0)
                                close = 1'b1;
                        end
                        if (count_next >= RX_LIMIT)
                            close = 1'b1;
                    end
                end
                ACT_TICK:
                begin
                    if (state_reg == ST_LISTEN)
                    begin
                        if (idle_reg >= timeout_reg)
                            close = 1'b1;
                        else if (idle_reg != IDLE_MAX)
                            idle_next = idle_reg + 1'b1;
                    end
                end
                default:
                begin
                    close = 1'b0;
                end
            endcase
        end

        if (close)
            state_next = ST_IDLE;

        res_ok     = 1'b0;
        res_reason = REASON_NONE;
        if (echo_bad_next)
            res_reason = REASON_ECHO;
        else if (count_next < 8'd3)
            res_reason = REASON_SHORT;
        else if (last0_next != crc_next[7:0] || last1_next != crc_next[15:8])
            res_reason = REASON_CRC;
        else
            res_ok = 1'b1;

        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        if (close)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {5'b0, count_next, res_reason, res_ok};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            timeout_reg   <= TIMEOUT_RESET;
            expected_reg  <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
            echo_bad_reg  <= 1'b0;
            idle_reg      <= '0;
            crc_reg       <= CRC_SEED;
            last0_reg     <= '0;
            last1_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            expected_reg  <= expected_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            echo_bad_reg  <= echo_bad_next;
            idle_reg      <= idle_next;
            crc_reg       <= crc_next;
            last0_reg     <= last0_next;
            last1_reg     <= last1_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
                timeout_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

// ===== src/modbus_rtu_response_checker.sv =====
// Top level of the Modbus RTU response checker.
// Takes one input word per clock and returns at most one result word per frame.
// Words are decoded, held in a four-entry command queue and executed one per
// cycle, including the full eight-bit CRC-16 update, so the sustained rate is one
// word per cycle; the word that closes the frame is queued, popped and executed,
// its result is registered, and input stalls only when the queue fills behind a
// stalled output. The idle timeout may be written at any time the block is quiet,
// with no start-up sweep after reset.
`default_nettype none
module modbus_rtu_response_checker
    import mrrc_pkg::*;
#(
    parameter int RX_BUFFER_BYTES = RX_BUFFER_BYTES_DEF,
    parameter int LAST_READ_CODE  = LAST_READ_CODE_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // request_code[7:0], rx_byte[15:8]
    input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // frame_ok[0], fail_reason[2:1], byte_count[10:3]
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    cmd_t q_cmd;
    cmd_t q_head;

    assign cfg_ready = 1'b1;

    mrrc_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    mrrc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    mrrc_back #(
        .RX_BUFFER_BYTES (RX_BUFFER_BYTES),
        .LAST_READ_CODE  (LAST_READ_CODE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
`default_nettype wire

// ===== src/mrrc_checker.sv =====
// Port-level checks for the response checker, bound to the top level.
`default_nettype none
`include "modbus_rtu_response_checker_defines.svh"
module mrrc_checker
    import mrrc_pkg::*;
#(
    parameter int RX_BUFFER_BYTES = RX_BUFFER_BYTES_DEF
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    localparam logic [7:0] RX_LIMIT = 8'(RX_BUFFER_BYTES);

    `MRRC_ASSERT(a_ok_matches_reason, clk, rst_n, m_axis_tvalid, (m_axis_tdata[0] == (m_axis_tdata[2:1] == REASON_NONE)), "frame_ok disagrees with fail_reason")
    `MRRC_ASSERT(a_short_count, clk, rst_n, m_axis_tvalid && (m_axis_tdata[2:1] == REASON_SHORT), (m_axis_tdata[10:3] < 8'd3), "short frame reported with three or more bytes")
    `MRRC_ASSERT(a_count_limit, clk, rst_n, m_axis_tvalid, (m_axis_tdata[10:3] <= RX_LIMIT) && (m_axis_tdata[15:11] == 5'd0), "byte count beyond buffer size")
    `MRRC_ASSERT_NEXT(a_hold_stalled, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result word changed")

endmodule

bind modbus_rtu_response_checker mrrc_checker #(
    .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== verif/modbus_rtu_response_checker_tb.sv =====
// Testbench for the Modbus RTU response checker: directed words, then random responses checked against a predictor.
`timescale 1ns / 100ps
module modbus_rtu_response_checker_tb;
    import mrrc_pkg::*;

    localparam int BUF_BYTES      = RX_BUFFER_BYTES_DEF;
    localparam int LAST_READ      = LAST_READ_CODE_DEF;
    localparam int STALL_LIMIT    = 4000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 12;
    localparam int PHASES         = 5;
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    localparam int SEND_IDLE_PCT [PHASES] = '{0, 79, 0, 26, 0};
    localparam int RECV_STALL_PCT [PHASES] = '{0, 0, 79, 26, 0};
    localparam int PHASE_TIMEOUT [PHASES] = '{100, 1, 65535, 0, 0};
    localparam int PHASE_WORDS [PHASES] = '{300, 300, 250, 300, 300};

    typedef struct packed {
        logic       ok;
        reason_t    reason;
        logic [7:0] count;
    } verdict_t;

    typedef struct packed {
        logic        is_cfg;
        logic [15:0] cfg_val;
        logic [1:0]  act;
        logic [7:0]  code;
        logic [7:0]  octet;
        logic        typed;
        verdict_t    want;
    } step_t;

    localparam verdict_t NO_VERDICT = '{1'b0, REASON_NONE, 8'd0};

    localparam step_t SCRIPT [29] = '{
        '{1'b0, 16'd0, ACT_BYTE,     8'h00, 8'hFF, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_TICK,     8'hFF, 8'h00, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_RESERVED, 8'hFF, 8'hFF, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_START,    8'h03, 8'h00, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_BYTE,     8'h00, 8'h11, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_BYTE,     8'h00, 8'h07, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_RESERVED, 8'h00, 8'h00, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_BYTE,     8'h00, 8'h00, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_BYTE,     8'h00, 8'hFF, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_BYTE,     8'h00, 8'h00, 1'b1, '{1'b0, REASON_ECHO, 8'd5}},
        '{1'b0, 16'd0, ACT_START,    8'hFF, 8'h00, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_BYTE,     8'h00, 8'h00, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_START,    8'h00, 8'hFF, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_BYTE,     8'h00, 8'h01, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_BYTE,     8'h00, 8'h00, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_BYTE,     8'h00, 8'h01, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_BYTE,     8'h00, 8'hAB, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_BYTE,     8'h00, 8'hCD, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_BYTE,     8'h00, 8'hEF, 1'b0, NO_VERDICT},
        '{1'b1, 16'd1, ACT_START,    8'h00, 8'h00, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_START,    8'h04, 8'h00, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_BYTE,     8'h00, 8'h01, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_TICK,     8'h00, 8'h00, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_TICK,     8'h00, 8'h00, 1'b1, '{1'b0, REASON_SHORT, 8'd1}},
        '{1'b0, 16'd0, ACT_START,    8'h10, 8'h00, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_BYTE,     8'h00, 8'h01, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_BYTE,     8'h00, 8'h11, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_TICK,     8'h00, 8'h00, 1'b0, NO_VERDICT},
        '{1'b0, 16'd0, ACT_TICK,     8'h00, 8'h00, 1'b1, '{1'b0, REASON_ECHO, 8'd2}}
    };

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data      = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'd0;  // request_code[7:0], rx_byte[15:8]
    logic [1:0]  s_axis_tuser  = 2'd0;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // frame_ok[0], fail_reason[2:1], byte_count[10:3]

    logic [15:0] timeout_reg   = TIMEOUT_RESET;
    bit          armed         = 1'b0;
    logic [7:0]  echo_want     = 8'd0;
    logic [7:0]  rx_total      = 8'd0;
    logic [8:0]  bytes_to_go   = 9'd0;
    bit          echo_bad      = 1'b0;
    logic [15:0] idle_count    = 16'd0;
    logic [15:0] crc_acc       = CRC_SEED;
    logic [7:0]  tail [2]      = '{8'd0, 8'd0};

    verdict_t    verdicts_due [$];
    int          words_live    = 0;
    int          results_seen  = 0;
    int          mismatches    = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    bit          hold_req      = 1'b0;
    int          hold_left     = 0;

    modbus_rtu_response_checker u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] octet);
        logic [15:0] r;
        r = acc ^ {8'h00, octet};
        repeat (8)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    task automatic predict_word(input logic [1:0] act, input logic [7:0] code,
                                input logic [7:0] octet, output bit closes, output verdict_t v);
        closes = 1'b0;
        v = NO_VERDICT;
        if (act == ACT_START)
        begin
            armed       = 1'b1;
            echo_want   = code;
            rx_total    = 8'd0;
            bytes_to_go = 9'd0;
            echo_bad    = 1'b0;
            idle_count  = 16'd0;
            crc_acc     = CRC_SEED;
            tail        = '{8'd0, 8'd0};
        end
        else if (armed && act == ACT_BYTE)
        begin
            if (rx_total >= 8'd2)
                crc_acc = crc16_step(crc_acc, tail[0]);
            tail[0]    = tail[1];
            tail[1]    = octet;
            rx_total   = rx_total + 8'd1;
            idle_count = 16'd0;
            if (rx_total == 8'd2)
            begin
                if (octet != echo_want)
                    echo_bad = 1'b1;
            end
            else if (rx_total == 8'd3)
                bytes_to_go = (echo_want <= LAST_READ) ? {1'b0, octet} + 9'd2 : 9'(BUF_BYTES);
            else if (rx_total > 8'd3)
            begin
                if (bytes_to_go != 9'd0)
                    bytes_to_go = bytes_to_go - 9'd1;
                if (bytes_to_go == 9'd0)
                    closes = 1'b1;
            end
            if (rx_total >= BUF_BYTES)
                closes = 1'b1;
        end
        else if (armed && act == ACT_TICK)
        begin
            if (idle_count >= timeout_reg)
                closes = 1'b1;
            else if (idle_count != IDLE_MAX)
                idle_count = idle_count + 16'd1;
        end
        if (closes)
        begin
            v.count = rx_total;
            v.ok    = 1'b0;
            if (echo_bad)
                v.reason = REASON_ECHO;
            else if (rx_total < 8'd3)
                v.reason = REASON_SHORT;
            else if (tail[0] != crc_acc[7:0] || tail[1] != crc_acc[15:8])
                v.reason = REASON_CRC;
            else
            begin
                v.reason = REASON_NONE;
                v.ok     = 1'b1;
            end
            armed = 1'b0;
        end
    endtask

    task automatic send_word(input logic [1:0] act, input logic [7:0] code, input logic [7:0] octet,
                             input bit typed, input verdict_t want);
        bit       closes;
        verdict_t v;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {octet, code};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (act == ACT_START || (armed && (act == ACT_BYTE || act == ACT_TICK)))
            words_live++;
        predict_word(act, code, octet, closes, v);
        if (closes)
            verdicts_due.push_back(typed ? want : v);
        @(negedge clk);
    endtask

    task automatic send(input logic [1:0] act, input logic [7:0] code, input logic [7:0] octet);
        send_word(act, code, octet, 1'b0, NO_VERDICT);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        timeout_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_response();
        logic [7:0]  code;
        logic [7:0]  frame [$];
        logic [15:0] crc;
        int          n;
        int          keep;
        int          gap_max;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            send(2'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)));
            return;
        end
        if (pick < 70)
            code = 8'($urandom_range(LAST_READ, 1));
        else if (pick < 76)
            code = 8'h00;
        else
            code = 8'($urandom_range(255, LAST_READ + 1));
        frame.push_back(8'($urandom_range(255)));
        frame.push_back(($urandom_range(99) < 92) ? code : 8'($urandom_range(255)));
        if (code <= LAST_READ)
        begin
            pick = $urandom_range(99);
            n = (pick < 85) ? $urandom_range(12) :
                (pick < 95) ? $urandom_range(59, 13) : $urandom_range(255, 60);
            frame.push_back(8'(n));
            if (n > BUF_BYTES - 3)
                n = BUF_BYTES - 3;
        end
        else
            n = ($urandom_range(99) < 80) ? $urandom_range(18, 1) : BUF_BYTES - 4;
        repeat (n)
            frame.push_back(8'($urandom_range(255)));
        crc = CRC_SEED;
        foreach (frame[i])
            crc = crc16_step(crc, frame[i]);
        if ($urandom_range(99) < 10)
            crc = crc ^ (16'd1 << $urandom_range(15));
        frame.push_back(crc[7:0]);
        frame.push_back(crc[15:8]);
        keep = (frame.size() > BUF_BYTES) ? BUF_BYTES : frame.size();
        if ($urandom_range(99) < 10)
            keep = $urandom_range(keep - 1);
        gap_max = (timeout_reg < 3) ? timeout_reg : 3;

        send(ACT_START, code, 8'($urandom_range(255)));
        for (int i = 0; i < keep; i++)
        begin
            if ($urandom_range(99) < 10)
                repeat ($urandom_range(gap_max, 1))
                    send(ACT_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
            if ($urandom_range(99) < 3)
                send(ACT_RESERVED, 8'($urandom_range(255)), 8'($urandom_range(255)));
            send(ACT_BYTE, 8'($urandom_range(255)), frame[i]);
        end
        // close by timer where the timeout is short enough
        if (armed && timeout_reg <= 300 && $urandom_range(99) < 85)
            repeat (int'(timeout_reg) + 1)
                send(ACT_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
        if ($urandom_range(99) < 3)
            wait_drained();
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("result %0d: %s got %0h want %0h", results_seen, what, got, want);
    endtask

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  <= 1'b0;
            hold_left = HOLDOFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        verdict_t due;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (verdicts_due.size() == 0)
                report_mismatch("unexpected word", m_axis_tdata, 16'd0);
            else
            begin
                due = verdicts_due.pop_front();
                if (m_axis_tdata[0] !== due.ok)
                    report_mismatch("frame_ok", 16'(m_axis_tdata[0]), 16'(due.ok));
                if (m_axis_tdata[2:1] !== due.reason)
                    report_mismatch("fail_reason", 16'(m_axis_tdata[2:1]), 16'(due.reason));
                if (m_axis_tdata[10:3] !== due.count)
                    report_mismatch("byte_count", 16'(m_axis_tdata[10:3]), 16'(due.count));
            end
            results_seen++;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        logic [15:0] timeout_pick;
        rst_n = 1'b0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (SCRIPT[i])
        begin
            if (SCRIPT[i].is_cfg)
            begin
                wait_drained();
                write_timeout(SCRIPT[i].cfg_val);
            end
            else
                send_word(SCRIPT[i].act, SCRIPT[i].code, SCRIPT[i].octet,
                          SCRIPT[i].typed, SCRIPT[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            timeout_pick = (PHASE_TIMEOUT[p] != 0) ? 16'(PHASE_TIMEOUT[p]) :
                           16'($urandom_range(40, 2));
            write_timeout(timeout_pick);
            send_idle_pct = SEND_IDLE_PCT[p];
            stall_pct     <= RECV_STALL_PCT[p];
            if (p == PHASES - 1)
                hold_req <= 1'b1;
            words_live = 0;
            while (words_live < PHASE_WORDS[p])
                send_response();
        end

        wait_drained();
        if (verdicts_due.size() != 0)
            report_mismatch("missing words", 16'(verdicts_due.size()), 16'd0);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/mrrc_pkg.sv
src/mrrc_front.sv
src/mrrc_fifo.sv
src/mrrc_back.sv
src/modbus_rtu_response_checker.sv
src/mrrc_checker.sv
verif/modbus_rtu_response_checker_tb.sv
